// File: rtl/irpd_pkg.sv
// irpd_pkg: shared types, codes and constants for the IR pulse-distance decoder.
// No dependencies; imported by irpd_csr and the decoder top level.
`default_nettype none

package irpd_pkg;

   localparam int NumHashRegs = 3;
   localparam int HashWidth   = 16;
   localparam int HeaderWidth = 5;

   // request action codes
   localparam logic [1:0] ActTick  = 2'd0;
   localparam logic [1:0] ActEdge  = 2'd1;
   localparam logic [1:0] ActAck   = 2'd2;
   localparam logic [1:0] ActClear = 2'd3;

   // register indexes
   localparam logic [2:0] RegHashUp       = 3'd0;
   localparam logic [2:0] RegHashDown     = 3'd1;
   localparam logic [2:0] RegHashOverride = 3'd2;
   localparam logic [2:0] RegLearnMode    = 3'd3;
   localparam logic [2:0] RegHeaderInit   = 3'd4;

   localparam logic [HashWidth-1:0] HashSeed = 16'd5381;
   localparam logic [7:0]           HoldMin  = 8'd10;
   localparam logic [7:0]           HoldMax  = 8'd255;

   typedef struct packed {
      logic [NumHashRegs-1:0][HashWidth-1:0] cmd_hash;
      logic                                  learn_mode;
   } cfg_type;

   typedef struct packed {
      logic                   wr;
      logic [HeaderWidth-1:0] value;
   } hdr_write_type;

   // hash * 17 + byte, modulo 2^16
   function automatic logic [HashWidth-1:0] fold_byte(input logic [HashWidth-1:0] hash,
                                                      input logic [7:0]           data);
      logic [HashWidth-1:0] shifted;
      shifted = {hash[HashWidth-5:0], 4'b0000};
      return shifted + hash + {8'b0, data};
   endfunction

endpackage

`default_nettype wire

// File: rtl/irpd_req_if.sv
// irpd_req_if: request channel (valid/ready, action and key line level).
// No dependencies.
`default_nettype none

interface irpd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic       key_low;

   modport source (output valid, output action, output key_low, input ready);
   modport sink   (input valid, input action, input key_low, output ready);
endinterface

`default_nettype wire

// File: rtl/irpd_rsp_if.sv
// irpd_rsp_if: response channel (valid/ready and decoder status fields).
// No dependencies.
`default_nettype none

interface irpd_rsp_if;
   logic        valid;
   logic        ready;
   logic        command_ready;
   logic [15:0] signature;
   logic        match_valid;
   logic [1:0]  match_index;
   logic [7:0]  key_hold;
   logic [4:0]  header_width;

   modport source (output valid, output command_ready, output signature,
                   output match_valid, output match_index, output key_hold,
                   output header_width, input ready);
   modport sink   (input valid, input command_ready, input signature,
                   input match_valid, input match_index, input key_hold,
                   input header_width, output ready);
endinterface

`default_nettype wire

// File: rtl/irpd_csr.sv
// irpd_csr: APB-style register file holding command hashes, learn mode and header init.
// Depends on irpd_pkg.
`default_nettype none

module irpd_csr
   import irpd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          psel,
   input  wire logic          penable,
   input  wire logic          pwrite,
   input  wire logic [4:0]    paddr,
   input  wire logic [31:0]   pwdata,
   output logic      [31:0]   prdata,
   output logic               pready,
   output cfg_type            cfg,
   output hdr_write_type      hdr_wr
);

   cfg_type                cfg_ff, cfg_in;
   logic [HeaderWidth-1:0] header_init_ff, header_init_in;
   logic                   wr_en;
   logic [2:0]             index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = paddr[4:2];

   always_comb begin
      cfg_in         = cfg_ff;
      header_init_in = header_init_ff;
      hdr_wr.wr      = 1'b0;
      hdr_wr.value   = pwdata[HeaderWidth-1:0];
      if (wr_en) begin
         unique case (index)
            RegHashUp:       cfg_in.cmd_hash[0] = pwdata[HashWidth-1:0];
            RegHashDown:     cfg_in.cmd_hash[1] = pwdata[HashWidth-1:0];
            RegHashOverride: cfg_in.cmd_hash[2] = pwdata[HashWidth-1:0];
            RegLearnMode:    cfg_in.learn_mode  = pwdata[0];
            RegHeaderInit: begin
               header_init_in = pwdata[HeaderWidth-1:0];
               hdr_wr.wr      = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         RegHashUp:       prdata = {16'b0, cfg_ff.cmd_hash[0]};
         RegHashDown:     prdata = {16'b0, cfg_ff.cmd_hash[1]};
         RegHashOverride: prdata = {16'b0, cfg_ff.cmd_hash[2]};
         RegLearnMode:    prdata = {31'b0, cfg_ff.learn_mode};
         RegHeaderInit:   prdata = {27'b0, header_init_ff};
         default:         prdata = 32'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff         <= '0;
         header_init_ff <= '0;
      end else begin
         cfg_ff         <= cfg_in;
         header_init_ff <= header_init_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/ir_pulse_distance_command_decoder_unit.sv
// ir_pulse_distance_command_decoder_unit: IR remote frame decoder top level.
// Depends on irpd_pkg, irpd_req_if, irpd_rsp_if and irpd_csr.
//
//   port    dir   handshake             carries
//   req     in    valid/ready           action, key_low
//   rsp     out   valid/ready           status, signature, match, key_hold, header
//   csr_*   in    APB (pready tied 1)   hash, learn mode and header init registers
//
// The decoder state and the response register are both updated at the accepting
// edge, so a response appears in the cycle after acceptance.
// req.ready is high whenever the response register is empty or being drained.
// Synchronous reset zeroes decoder state, rsp.valid and configuration, not rsp data.
`default_nettype none

module ir_pulse_distance_command_decoder_unit
   import irpd_pkg::*;
#(
   parameter int NUM_COMMANDS = 3
)(
   input  wire logic        clock,
   input  wire logic        reset,
   irpd_req_if.sink         req,
   irpd_rsp_if.source       rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   localparam int NumActive = (NUM_COMMANDS < NumHashRegs) ? NUM_COMMANDS : NumHashRegs;

   localparam logic [1:0] PhIdle  = 2'd0;
   localparam logic [1:0] PhFirst = 2'd1;
   localparam logic [1:0] PhRecv  = 2'd2;
   localparam logic [1:0] PhDone  = 2'd3;

   cfg_type       cfg;
   hdr_write_type hdr_wr;

   irpd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg),
      .hdr_wr  (hdr_wr)
   );

   logic [1:0]             phase_ff, phase_in;
   logic [7:0]             interval_ff, interval_in;
   logic [7:0]             prev_ff, prev_in;
   logic [2:0]             bit_idx_ff, bit_idx_in;
   logic [7:0]             pbyte_ff, pbyte_in;
   logic [HashWidth-1:0]   hash_ff, hash_in;
   logic [HeaderWidth-1:0] header_ff, header_in;
   logic [7:0]             hold_ff, hold_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   cmd_ready_ff, cmd_ready_in;
   logic [HashWidth-1:0]   sig_ff;
   logic                   match_valid_ff, match_valid_in;
   logic [1:0]             match_idx_ff, match_idx_in;
   logic [7:0]             key_hold_ff;
   logic [HeaderWidth-1:0] hdr_width_ff;

   logic                   req_fire;
   logic [7:0]             tick_count;
   logic [4:0]             head;
   logic [7:0]             diff;
   logic                   data_bit;
   logic [7:0]             shifted_byte;
   logic [2:0]             bit_idx_next;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_fire  = req.valid && req.ready;

   assign tick_count   = interval_ff + 8'd1;
   assign head         = interval_ff[7:3];
   assign diff         = (interval_ff > prev_ff) ? (interval_ff - prev_ff)
                                                 : (prev_ff - interval_ff);
   assign data_bit     = (interval_ff > prev_ff) ? (diff > {1'b0, prev_ff[7:1]})
                                                 : (diff > {1'b0, interval_ff[7:1]});
   assign shifted_byte = {pbyte_ff[6:0], data_bit};
   assign bit_idx_next = bit_idx_ff + 3'd1;

   // decoder state update
   always_comb begin
      phase_in    = phase_ff;
      interval_in = interval_ff;
      prev_in     = prev_ff;
      bit_idx_in  = bit_idx_ff;
      pbyte_in    = pbyte_ff;
      hash_in     = hash_ff;
      header_in   = header_ff;
      hold_in     = hold_ff;
      if (req_fire) begin
         unique case (req.action)
            ActTick: begin
               interval_in = tick_count;
               if (tick_count == 8'd0 && phase_ff != PhDone) begin
                  if (req.key_low) begin
                     if (hold_ff != HoldMax) begin
                        hold_in = hold_ff + 8'd1;
                     end
                     phase_in = PhIdle;
                  end else begin
                     if (phase_ff == PhRecv && header_ff != '0) begin
                        phase_in = PhDone;
                        hash_in  = fold_byte(hash_ff, pbyte_ff);
                     end else begin
                        phase_in = PhIdle;
                     end
                     if (hold_ff < HoldMin) begin
                        hold_in = 8'd0;
                     end
                  end
               end
            end
            ActEdge: begin
               if (phase_ff == PhIdle) begin
                  phase_in    = PhFirst;
                  prev_in     = 8'd0;
                  bit_idx_in  = 3'd0;
                  pbyte_in    = 8'd0;
                  hash_in     = HashSeed;
                  interval_in = 8'd0;
               end else if (phase_ff != PhDone) begin
                  if (phase_ff == PhFirst) begin
                     if (head == header_ff) begin
                        phase_in = PhRecv;
                     end else if (cfg.learn_mode) begin
                        header_in = head;
                        phase_in  = PhRecv;
                     end else begin
                        phase_in = PhIdle;
                     end
                  end
                  bit_idx_in = bit_idx_next;
                  if (bit_idx_next == 3'd0) begin
                     hash_in  = fold_byte(hash_ff, shifted_byte);
                     pbyte_in = 8'd0;
                  end else begin
                     pbyte_in = shifted_byte;
                  end
                  prev_in     = interval_ff;
                  interval_in = 8'd0;
               end
            end
            ActAck: begin
               if (phase_ff == PhDone) begin
                  phase_in = PhIdle;
               end
            end
            ActClear: hold_in = 8'd0;
            default: ;
         endcase
      end
      if (hdr_wr.wr) begin
         header_in = hdr_wr.value;
      end
   end

   // command match on the updated hash
   always_comb begin
      cmd_ready_in   = (phase_in == PhDone);
      match_valid_in = 1'b0;
      match_idx_in   = 2'd0;
      if (cmd_ready_in) begin
         for (int i = 0; i < NumActive; i++) begin
            if (!match_valid_in && hash_in == cfg.cmd_hash[i]) begin
               match_valid_in = 1'b1;
               match_idx_in   = 2'(i);
            end
         end
      end
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PhIdle;
         interval_ff  <= '0;
         prev_ff      <= '0;
         bit_idx_ff   <= '0;
         pbyte_ff     <= '0;
         hash_ff      <= '0;
         header_ff    <= '0;
         hold_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         interval_ff  <= interval_in;
         prev_ff      <= prev_in;
         bit_idx_ff   <= bit_idx_in;
         pbyte_ff     <= pbyte_in;
         hash_ff      <= hash_in;
         header_ff    <= header_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ready_ff   <= cmd_ready_in;
         sig_ff         <= hash_in;
         match_valid_ff <= match_valid_in;
         match_idx_ff   <= match_idx_in;
         key_hold_ff    <= hold_in;
         hdr_width_ff   <= header_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.command_ready = cmd_ready_ff;
   assign rsp.signature     = sig_ff;
   assign rsp.match_valid   = match_valid_ff;
   assign rsp.match_index   = match_idx_ff;
   assign rsp.key_hold      = key_hold_ff;
   assign rsp.header_width  = hdr_width_ff;

   // every accepted transaction leaves a response behind
   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted transaction produced no response");

   // decoder phase only moves on an accepted transaction
   a_phase_quiet: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(phase_ff))
      else $error("phase changed without a transaction");

   // key hold counter saturates on a wrap tick
   a_hold_saturates: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req.action == ActTick && hold_ff == HoldMax) |=> hold_ff == HoldMax)
      else $error("key hold counter left saturation on a tick");

   // a held frame keeps its signature until acknowledged
   a_done_hash_held: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PhDone && !(req_fire && req.action == ActAck) && !hdr_wr.wr)
      |=> (phase_ff == PhDone && $stable(hash_ff)))
      else $error("received frame changed before acknowledge");

endmodule

`default_nettype wire
